[sv/gps_pkg.sv]
// Gripper position sequencer: shared types and constants.
// Used by gripper_position_sequencer_unit; depends on nothing.
package gps_pkg;

	typedef enum logic [2:0] {
		PH_CAL_START   = 3'd0,
		PH_SEEK        = 3'd1,
		PH_TEST_TURN   = 3'd2,
		PH_GO_MAGNET   = 3'd3,
		PH_OPEN_TO_MAG = 3'd4,
		PH_CHECK       = 3'd5,
		PH_ROTATE      = 3'd6,
		PH_GRIP        = 3'd7
	} phase_t;

	localparam logic [2:0] K_TICK  = 3'd0;
	localparam logic [2:0] K_ANGLE = 3'd1;
	localparam logic [2:0] K_OPEN  = 3'd2;
	localparam logic [2:0] K_CLOSE = 3'd3;
	localparam logic [2:0] K_CAL   = 3'd4;

	localparam logic [1:0] REG_MARGIN = 2'd0;
	localparam logic [1:0] REG_SPEED  = 2'd1;
	localparam logic [1:0] REG_CPR    = 2'd2;

	localparam logic [9:0]  RST_MARGIN = 10'd5;
	localparam logic [7:0]  RST_SPEED  = 8'd50;
	localparam logic [17:0] RST_CPR    = 18'd59059;

	localparam logic [7:0] HALL_ABSENT = 8'd255;
	localparam logic [7:0] HALL_MAGNET = 8'd0;
	localparam logic [9:0] GRIP_BOOST  = 10'd50;
	localparam logic [9:0] HALF_EXTRA  = 10'd10;

	// degrees to ticks: a*C / (360*256) = ((a*C) >> 11) / 45
	// divide by 45 as multiply by ceil(2^29/45), exact for 23-bit dividends
	localparam int          RECIP_SHIFT = 29;
	localparam logic [23:0] RECIP_45    = 24'd11930465;

	typedef struct packed {
		logic        open_now;
		logic [31:0] target;
		logic [9:0]  speed;
		logic        speed_written;
		logic [2:0]  mode;
	} result_t;

endpackage

[sv/gripper_position_sequencer_unit.sv]
// Gripper position sequencer top level: input stage, sequencer step, result register.
// Depends on gps_pkg.
//
//  channel | dir | handshake                      | word
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | tick or command
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | one result per input word
//  cfg     | in  | cfg_valid / cfg_ready          | register index and value
//
// One word per cycle while the result is taken: the input register carries the degree
// product, the step divides it by 45 and updates the sequencer state.
// arst_n returns the sequencer state, config and valid flags to reset values; data registers are not reset.
// A stalled result holds; the input stage keeps accepting while the result
// register is free or being taken. cfg_ready is always high.
module gripper_position_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // hall_value[7:0], encoder_position[39:8], angle_degrees[55:40]
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // mode[2:0], speed_written[3], speed_command[13:4],
	                                   // motor_target[45:14], gripper_open[46], zero[47]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	logic [9:0]  margin_q;
	logic [7:0]  speed_q;
	logic [17:0] cpr_q;

	gps_pkg::phase_t phase_q, nxt_phase;
	logic [17:0] now_q, nxt_now;
	logic [17:0] goal_q, nxt_goal;
	logic        open_now_q, nxt_open_now;
	logic        open_goal_q, nxt_open_goal;
	logic [31:0] target_q, nxt_target;
	logic [9:0]  spd_q, nxt_spd;
	logic        nxt_flag;

	logic        v_s1;
	logic [2:0]  kind_s1;
	logic [7:0]  hall_s1;
	logic [31:0] enc_s1;
	logic [33:0] prod_s1;

	logic              m_valid_q;
	gps_pkg::result_t  res_q, res_d;

	logic        advance;
	logic [46:0] recip_prod;

	assign cfg_ready     = 1'b1;
	assign advance       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !v_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, res_q};
	assign recip_prod    = prod_s1[33:11] * gps_pkg::RECIP_45;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= gps_pkg::RST_MARGIN;
			speed_q  <= gps_pkg::RST_SPEED;
			cpr_q    <= gps_pkg::RST_CPR;
		end else if (cfg_valid) begin
			case (cfg_index)
				gps_pkg::REG_MARGIN: margin_q <= cfg_data[9:0];
				gps_pkg::REG_SPEED:  speed_q  <= cfg_data[7:0];
				gps_pkg::REG_CPR:    cpr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage; degree product taken here so the step holds one multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			hall_s1 <= s_axis_tdata[7:0];
			enc_s1  <= s_axis_tdata[39:8];
			prod_s1 <= s_axis_tdata[55:40] * cpr_q;
		end
	end

	function automatic logic turn_done(input logic [31:0] tgt, input logic [31:0] enc,
	                                   input logic [9:0] m, input logic grip);
		logic signed [32:0] d;
		logic signed [32:0] mm;
		d  = $signed({tgt[31], tgt}) - $signed({enc[31], enc});
		mm = $signed({23'd0, m});
		if (grip)
			return d <= mm;
		return d >= -mm;
	endfunction

	always_comb begin
		logic        mag;
		logic        drv_en, drv_grip;
		logic [7:0]  drv_mag;
		logic        tb_en, tb_grip;
		logic [15:0] tb_len;
		logic [7:0]  quarter;
		logic [9:0]  half_len;
		logic [9:0]  full;
		logic signed [18:0] d;
		logic [18:0] ad;
		logic [18:0] len;

		nxt_phase     = phase_q;
		nxt_now       = now_q;
		nxt_goal      = goal_q;
		nxt_open_now  = open_now_q;
		nxt_open_goal = open_goal_q;
		nxt_target    = target_q;
		nxt_spd       = spd_q;
		nxt_flag      = 1'b0;
		mag      = (hall_s1 == gps_pkg::HALL_MAGNET);
		drv_en   = 1'b0;
		drv_grip = 1'b0;
		drv_mag  = 8'd0;
		tb_en    = 1'b0;
		tb_grip  = 1'b0;
		tb_len   = 16'd0;
		quarter  = cpr_q[17:10];
		half_len = {1'b0, cpr_q[17:9]} + gps_pkg::HALF_EXTRA;
		full     = cpr_q[17:8];
		d        = $signed({1'b0, goal_q}) - $signed({1'b0, now_q});
		ad       = d[18] ? 19'(-d) : 19'(d);
		len      = (d <= 19'sd0) ? ad : ({9'd0, full} - ad);

		case (kind_s1)
			gps_pkg::K_TICK: begin
				case (phase_q)
					gps_pkg::PH_CAL_START: begin
						drv_en = 1'b1;
						if (hall_s1 == gps_pkg::HALL_ABSENT) begin
							nxt_phase = gps_pkg::PH_CHECK;
						end else if (mag) begin
							tb_en     = 1'b1;
							tb_grip   = 1'b1;
							tb_len    = {8'd0, quarter};
							nxt_phase = gps_pkg::PH_TEST_TURN;
						end else begin
							drv_mag   = speed_q;
							nxt_phase = gps_pkg::PH_SEEK;
						end
					end
					gps_pkg::PH_SEEK: begin
						if (mag) begin
							drv_en    = 1'b1;
							tb_en     = 1'b1;
							tb_grip   = 1'b1;
							tb_len    = {8'd0, quarter};
							nxt_phase = gps_pkg::PH_TEST_TURN;
						end
					end
					gps_pkg::PH_TEST_TURN: begin
						if (turn_done(target_q, enc_s1, margin_q, 1'b1)) begin
							drv_en = 1'b1;
							if (mag) begin
								tb_en     = 1'b1;
								tb_len    = {6'd0, half_len};
								nxt_phase = gps_pkg::PH_GO_MAGNET;
							end else begin
								drv_mag   = speed_q;
								drv_grip  = 1'b1;
								nxt_phase = gps_pkg::PH_OPEN_TO_MAG;
							end
						end
					end
					gps_pkg::PH_GO_MAGNET: begin
						if (turn_done(target_q, enc_s1, margin_q, 1'b0)) begin
							drv_en = 1'b1;
							if (mag) begin
								nxt_now      = {10'd0, quarter};
								nxt_open_now = 1'b1;
								nxt_phase    = gps_pkg::PH_CHECK;
							end else begin
								drv_mag   = speed_q;
								drv_grip  = 1'b1;
								nxt_phase = gps_pkg::PH_OPEN_TO_MAG;
							end
						end
					end
					gps_pkg::PH_OPEN_TO_MAG: begin
						if (mag) begin
							drv_en       = 1'b1;
							nxt_now      = {10'd0, quarter};
							nxt_open_now = 1'b1;
							nxt_phase    = gps_pkg::PH_CHECK;
						end
					end
					gps_pkg::PH_CHECK: begin
						if (ad > {9'd0, margin_q}) begin
							tb_en     = 1'b1;
							tb_len    = len[15:0];
							nxt_phase = gps_pkg::PH_ROTATE;
						end else if (open_goal_q != open_now_q) begin
							tb_en     = 1'b1;
							tb_grip   = 1'b1;
							tb_len    = {8'd0, quarter};
							nxt_phase = gps_pkg::PH_GRIP;
						end
					end
					gps_pkg::PH_ROTATE: begin
						if (turn_done(target_q, enc_s1, margin_q, 1'b0)) begin
							drv_en  = 1'b1;
							nxt_now = goal_q;
							if (open_goal_q != open_now_q) begin
								tb_en     = 1'b1;
								tb_grip   = 1'b1;
								tb_len    = {8'd0, quarter};
								nxt_phase = gps_pkg::PH_GRIP;
							end else begin
								nxt_phase = gps_pkg::PH_CHECK;
							end
						end
					end
					default: begin
						if (turn_done(target_q, enc_s1, margin_q, 1'b1)) begin
							nxt_open_now = open_goal_q;
							drv_en       = 1'b1;
							nxt_phase    = gps_pkg::PH_CHECK;
						end
					end
				endcase
			end
			gps_pkg::K_ANGLE: begin
				if (phase_q == gps_pkg::PH_CHECK)
					nxt_goal = recip_prod[46:gps_pkg::RECIP_SHIFT];
			end
			gps_pkg::K_OPEN: begin
				if (phase_q == gps_pkg::PH_CHECK)
					nxt_open_goal = 1'b1;
			end
			gps_pkg::K_CLOSE: begin
				if (phase_q == gps_pkg::PH_CHECK)
					nxt_open_goal = 1'b0;
			end
			gps_pkg::K_CAL: begin
				nxt_phase = gps_pkg::PH_CAL_START;
			end
			default: ;
		endcase

		// a turn is always the last action of a step
		if (tb_en) begin
			nxt_target = tb_grip ? (enc_s1 + {16'd0, tb_len}) : (enc_s1 - {16'd0, tb_len});
			if (tb_len > {6'd0, margin_q}) begin
				drv_en   = 1'b1;
				drv_mag  = speed_q;
				drv_grip = tb_grip;
			end
		end

		if (drv_en) begin
			nxt_flag = 1'b1;
			nxt_spd  = drv_grip ? ({2'd0, drv_mag} + gps_pkg::GRIP_BOOST)
			                    : (10'd0 - {2'd0, drv_mag});
		end

		res_d.mode          = nxt_phase;
		res_d.speed_written = nxt_flag;
		res_d.speed         = nxt_spd;
		res_d.target        = nxt_target;
		res_d.open_now      = nxt_open_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= gps_pkg::PH_CHECK;
			now_q       <= '0;
			goal_q      <= '0;
			open_now_q  <= 1'b1;
			open_goal_q <= 1'b1;
			target_q    <= '0;
			spd_q       <= '0;
			m_valid_q   <= 1'b0;
		end else if (advance) begin
			m_valid_q <= v_s1;
			if (v_s1) begin
				phase_q     <= nxt_phase;
				now_q       <= nxt_now;
				goal_q      <= nxt_goal;
				open_now_q  <= nxt_open_now;
				open_goal_q <= nxt_open_goal;
				target_q    <= nxt_target;
				spd_q       <= nxt_spd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1)
			res_q <= res_d;
	end

endmodule

[sim/gripper_position_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for gripper_position_sequencer_unit: queued tick/command words,
// a word-level sequencer predictor and a field-by-field result check.
// Depends on gps_pkg and gripper_position_sequencer_unit.
module gripper_position_sequencer_unit_tb;

	localparam logic [2:0] K_UNUSED_LO = 3'd5;
	localparam logic [2:0] K_UNUSED_HI = 3'd7;
	localparam logic [1:0] REG_NONE    = 2'd3;
	localparam longint     DEG_DIVISOR = 360 * 256;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         PHASE_WORDS = 155;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  hall;
		logic [31:0] enc;
		logic [15:0] angle;
	} cmd_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = gps_pkg::K_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = gps_pkg::REG_MARGIN;
	logic [17:0] cfg_data = '0;

	gripper_position_sequencer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sequencer shadow state
	logic [9:0]         seq_margin = gps_pkg::RST_MARGIN;
	logic [7:0]         seq_drive = gps_pkg::RST_SPEED;
	logic [17:0]        seq_cpr = gps_pkg::RST_CPR;
	gps_pkg::phase_t    seq_phase = gps_pkg::PH_CHECK;
	logic signed [31:0] seq_angle_now = '0;
	logic signed [31:0] seq_angle_goal = '0;
	bit                 seq_open_now = 1'b1;
	bit                 seq_open_goal = 1'b1;
	logic signed [31:0] seq_target = '0;
	logic signed [31:0] seq_enc = '0;
	logic [9:0]         seq_speed = '0;
	bit                 seq_speed_flag = 1'b0;

	cmd_word_t         pending_commands[$];
	gps_pkg::result_t  gripper_results_due[$];
	cmd_word_t         word_on_bus;
	bit        idle_on = 1'b1;
	int        send_gap = 0;
	int        hold_left = 0;
	int        results_seen = 0;
	int        fail_count = 0;
	int        quiet_cycles = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void apply_drive(input logic [7:0] mag, input bit grip);
		seq_speed = grip ? 10'(mag) + gps_pkg::GRIP_BOOST : -10'(mag);
		seq_speed_flag = 1'b1;
	endfunction

	function automatic void start_turn(input logic [15:0] len, input bit grip);
		seq_target = grip ? seq_enc + 32'(len) : seq_enc - 32'(len);
		if (len > seq_margin)
			apply_drive(seq_drive, grip);
	endfunction

	function automatic bit turn_reached(input bit grip);
		longint d;
		d = longint'(seq_target) - longint'(seq_enc);
		return grip ? (d <= longint'(seq_margin)) : (d >= -longint'(seq_margin));
	endfunction

	function automatic void start_grip_toggle();
		seq_phase = gps_pkg::PH_GRIP;
		start_turn(16'(seq_cpr >> 10), 1'b1);
	endfunction

	function automatic void sequencer_step(input cmd_word_t w);
		longint            d;
		longint            ad;
		longint            len;
		bit                magnet;
		gps_pkg::result_t  r;
		seq_speed_flag = 1'b0;
		magnet = (w.hall == gps_pkg::HALL_MAGNET);
		case (w.kind)
			gps_pkg::K_TICK: begin
				seq_enc = w.enc;
				case (seq_phase)
					gps_pkg::PH_CAL_START: begin
						apply_drive(8'd0, 1'b0);
						if (w.hall == gps_pkg::HALL_ABSENT) begin
							seq_phase = gps_pkg::PH_CHECK;
						end else if (magnet) begin
							start_turn(16'(seq_cpr >> 10), 1'b1);
							seq_phase = gps_pkg::PH_TEST_TURN;
						end else begin
							apply_drive(seq_drive, 1'b0);
							seq_phase = gps_pkg::PH_SEEK;
						end
					end
					gps_pkg::PH_SEEK: begin
						if (magnet) begin
							apply_drive(8'd0, 1'b0);
							start_turn(16'(seq_cpr >> 10), 1'b1);
							seq_phase = gps_pkg::PH_TEST_TURN;
						end
					end
					gps_pkg::PH_TEST_TURN: begin
						if (turn_reached(1'b1)) begin
							apply_drive(8'd0, 1'b0);
							if (magnet) begin
								start_turn(16'((seq_cpr >> 9) + gps_pkg::HALF_EXTRA), 1'b0);
								seq_phase = gps_pkg::PH_GO_MAGNET;
							end else begin
								apply_drive(seq_drive, 1'b1);
								seq_phase = gps_pkg::PH_OPEN_TO_MAG;
							end
						end
					end
					gps_pkg::PH_GO_MAGNET: begin
						if (turn_reached(1'b0)) begin
							apply_drive(8'd0, 1'b0);
							if (magnet) begin
								seq_angle_now = 32'(seq_cpr >> 10);
								seq_open_now = 1'b1;
								seq_phase = gps_pkg::PH_CHECK;
							end else begin
								apply_drive(seq_drive, 1'b1);
								seq_phase = gps_pkg::PH_OPEN_TO_MAG;
							end
						end
					end
					gps_pkg::PH_OPEN_TO_MAG: begin
						if (magnet) begin
							apply_drive(8'd0, 1'b0);
							seq_angle_now = 32'(seq_cpr >> 10);
							seq_open_now = 1'b1;
							seq_phase = gps_pkg::PH_CHECK;
						end
					end
					gps_pkg::PH_CHECK: begin
						d = longint'(seq_angle_goal) - longint'(seq_angle_now);
						ad = (d < 0) ? -d : d;
						if (ad > longint'(seq_margin)) begin
							len = (d <= 0) ? ad : longint'(seq_cpr >> 8) - ad;
							start_turn(len[15:0], 1'b0);
							seq_phase = gps_pkg::PH_ROTATE;
						end else if (seq_open_goal != seq_open_now) begin
							start_grip_toggle();
						end
					end
					gps_pkg::PH_ROTATE: begin
						if (turn_reached(1'b0)) begin
							apply_drive(8'd0, 1'b0);
							seq_angle_now = seq_angle_goal;
							if (seq_open_goal != seq_open_now)
								start_grip_toggle();
							else
								seq_phase = gps_pkg::PH_CHECK;
						end
					end
					default: begin
						if (turn_reached(1'b1)) begin
							seq_open_now = seq_open_goal;
							apply_drive(8'd0, 1'b0);
							seq_phase = gps_pkg::PH_CHECK;
						end
					end
				endcase
			end
			gps_pkg::K_ANGLE: begin
				if (seq_phase == gps_pkg::PH_CHECK)
					seq_angle_goal = 32'((64'(w.angle) * 64'(seq_cpr)) / DEG_DIVISOR);
			end
			gps_pkg::K_OPEN: begin
				if (seq_phase == gps_pkg::PH_CHECK)
					seq_open_goal = 1'b1;
			end
			gps_pkg::K_CLOSE: begin
				if (seq_phase == gps_pkg::PH_CHECK)
					seq_open_goal = 1'b0;
			end
			gps_pkg::K_CAL: seq_phase = gps_pkg::PH_CAL_START;
			default: ;
		endcase
		r.mode = seq_phase;
		r.speed_written = seq_speed_flag;
		r.speed = seq_speed;
		r.target = seq_target;
		r.open_now = seq_open_now;
		gripper_results_due.push_back(r);
	endfunction

	task automatic report_mismatch(input string field, input logic [47:0] got,
			input logic [47:0] want);
		if (fail_count < 50)
			$display("mismatch: %s of result %0d is %0h, expected %0h",
				field, results_seen, got, want);
		fail_count++;
	endtask

	task automatic check_result(input logic [47:0] data);
		gps_pkg::result_t want;
		results_seen++;
		if (gripper_results_due.size() == 0) begin
			report_mismatch("word with nothing due", data, '0);
		end else begin
			want = gripper_results_due.pop_front();
			if (data[2:0] !== want.mode)
				report_mismatch("mode", data[2:0], want.mode);
			if (data[3] !== want.speed_written)
				report_mismatch("speed_written", data[3], want.speed_written);
			if (data[13:4] !== want.speed)
				report_mismatch("speed_command", data[13:4], want.speed);
			if (data[45:14] !== want.target)
				report_mismatch("motor_target", data[45:14], want.target);
			if (data[46] !== want.open_now)
				report_mismatch("gripper_open", data[46], want.open_now);
			if (data[47] !== 1'b0)
				report_mismatch("pad bit", data[47], 1'b0);
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sequencer_step(word_on_bus);
				send_gap = idle_on ? pick_gap() : 0;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0 || pending_commands.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					s_axis_tvalid <= 1'b0;
				end else begin
					word_on_bus = pending_commands.pop_front();
					s_axis_tdata <= {word_on_bus.angle, word_on_bus.enc, word_on_bus.hall};
					s_axis_tuser <= word_on_bus.kind;
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	// receiver; long hold-offs at fixed result counts to back the block up
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tdata);
				if (results_seen == 400 || results_seen == 800)
					hold_left = 150;
				else if (idle_on)
					hold_left = pick_gap();
			end else if (!m_axis_tvalid && idle_on && hold_left == 0
					&& $urandom_range(0, 9) == 0) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("gripper_position_sequencer_unit test failed");
			$finish;
		end
	end

	function automatic void queue_cmd(input logic [2:0] kind, input logic [7:0] hall,
			input logic [31:0] enc, input logic [15:0] angle);
		cmd_word_t w;
		w.kind = kind;
		w.hall = hall;
		w.enc = enc;
		w.angle = angle;
		pending_commands.push_back(w);
	endfunction

	function automatic cmd_word_t random_command();
		cmd_word_t w;
		int        pick;
		int        m;
		m = seq_margin;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			w.hall = gps_pkg::HALL_MAGNET;
		else if (pick < 45)
			w.hall = gps_pkg::HALL_ABSENT;
		else
			w.hall = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45)
			w.enc = seq_target + $urandom_range(0, 2 * m + 16) - (m + 8);
		else if (pick < 65)
			w.enc = seq_target + $urandom_range(m + 1, m + 70000);
		else if (pick < 80)
			w.enc = seq_target - $urandom_range(m + 1, m + 70000);
		else if (pick < 85)
			case ($urandom_range(0, 3))
				0: w.enc = 32'h7FFF_FFFF;
				1: w.enc = 32'h8000_0000;
				2: w.enc = 32'h0000_0000;
				default: w.enc = 32'hFFFF_FFFF;
			endcase
		else
			w.enc = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			w.angle = 16'($urandom_range(0, 400));
		else if (pick < 85)
			w.angle = 16'($urandom);
		else
			w.angle = (pick < 93) ? 16'hFFFF : 16'h0000;
		pick = $urandom_range(0, 99);
		if (pick < 68)
			w.kind = gps_pkg::K_TICK;
		else if (pick < 77)
			w.kind = gps_pkg::K_ANGLE;
		else if (pick < 82)
			w.kind = gps_pkg::K_OPEN;
		else if (pick < 87)
			w.kind = gps_pkg::K_CLOSE;
		else if (pick < 92)
			w.kind = gps_pkg::K_CAL;
		else if (pick < 96)
			w.kind = 3'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
		else
			w.kind = gps_pkg::K_TICK;
		return w;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_commands.size() != 0 || s_axis_tvalid
			|| gripper_results_due.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gps_pkg::REG_MARGIN: seq_margin = val[9:0];
			gps_pkg::REG_SPEED:  seq_drive = val[7:0];
			gps_pkg::REG_CPR:    seq_cpr = val;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [17:0] margin, input logic [17:0] speed,
			input logic [17:0] cpr);
		write_reg(gps_pkg::REG_MARGIN, margin);
		write_reg(gps_pkg::REG_SPEED, speed);
		write_reg(gps_pkg::REG_CPR, cpr);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_ABSENT, 32'h0, 16'h0);
		queue_cmd(K_UNUSED_HI, 8'hAA, 32'h5555_5555, 16'h5555);
		queue_cmd(K_UNUSED_LO, 8'h55, 32'hAAAA_AAAA, 16'hAAAA);
		queue_cmd(K_UNUSED_LO + 3'd1, 8'h0F, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_CLOSE, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'h55, 32'h7FFF_FFFF, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'hF0, 32'h8000_0038, 16'h0);
		queue_cmd(gps_pkg::K_ANGLE, 8'h0, 32'h0, 16'hFFFF);
		queue_cmd(gps_pkg::K_OPEN, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_MAGNET, 32'hFFFF_FFFF, 16'h0);
		// commands outside check are ignored
		queue_cmd(gps_pkg::K_ANGLE, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_CLOSE, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'h33, 32'h8000_0000, 16'h0);
		queue_cmd(gps_pkg::K_CAL, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_ABSENT, 32'h0, 16'h0);
		// full calibration walk
		queue_cmd(gps_pkg::K_CAL, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'h12, 32'd0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'h01, 32'd0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_MAGNET, 32'd1000, 16'h0);
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_MAGNET, 32'd1057, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'h80, 32'd932, 16'h0);
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_MAGNET, 32'd932, 16'h0);
		queue_cmd(gps_pkg::K_CAL, 8'h0, 32'h0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, gps_pkg::HALL_MAGNET, 32'd0, 16'h0);
		queue_cmd(gps_pkg::K_TICK, 8'h40, 32'd100, 16'h0);

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				wait_drained();
				repeat (4) @(posedge clk);
				case (p)
					1: write_all_regs(18'd0, 18'd255, 18'd262143);
					2: write_all_regs(18'h3FFFF, 18'd0, 18'd256);
					3: begin
						write_reg(REG_NONE, 18'($urandom));
						write_all_regs(18'd3, 18'h3FF80, 18'd120000);
					end
					4: write_all_regs(18'($urandom_range(0, 60)), 18'($urandom),
						18'($urandom_range(256, 262143)));
					default: write_all_regs(18'($urandom_range(0, 20)), 18'd200,
						18'($urandom_range(0, 300)));
				endcase
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				do
					@(negedge clk);
				while (pending_commands.size() >= 2);
				idle_on = ((n / 40) % 3) != 2;
				pending_commands.push_back(random_command());
				if (p == 2 && n == 70)
					wait_drained();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("gripper_position_sequencer_unit test passed");
		else
			$display("gripper_position_sequencer_unit test failed");
		$finish;
	end

endmodule
